// ===== rtl/dpb_pkg.sv =====
// shared types, constants and helper functions of the depth back-projection block
package dpb_pkg;

  // field widths
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int COORD_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register widths
  localparam int CX_W  = 18;
  localparam int CY_W  = 17;
  localparam int INV_W = 24;
  localparam int NUM_W = 32;

  // frame limits
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int FRAME_CMP_W  = 13;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_MODE  = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_INV_FOCAL_X = 3'd3,
    REG_INV_FOCAL_Y = 3'd4,
    REG_DISP_NUM    = 3'd5,
    REG_DISP_OFFSET = 3'd6
  } cfg_reg_t;

  // register reset values
  localparam logic            RST_DEPTH_MODE = 1'b0;
  localparam logic [CX_W-1:0]  RST_CENTER_X   = 18'd81920;
  localparam logic [CY_W-1:0]  RST_CENTER_Y   = 17'd61440;
  localparam logic [INV_W-1:0] RST_INV_FOCAL  = 24'd28679;
  localparam logic [NUM_W-1:0] RST_DISP_NUM   = 32'd23022797;
  localparam logic [NUM_W-1:0] RST_DISP_OFF   = 32'd71598080;

  // metric depth limits
  localparam logic [DEPTH_W-1:0] DEPTH_MISSING = 16'hFFFF;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN     = 16'd10;

  // metric z = floor((8192*d + 62) / 125), done as multiply by ceil(2^37/125)
  localparam int              METRIC_N_W    = 30;
  localparam int              METRIC_MUL_W  = 31;
  localparam int              METRIC_PROD_W = METRIC_N_W + METRIC_MUL_W;
  localparam logic [METRIC_N_W-1:0]   METRIC_BIAS = 30'd62;
  localparam logic [METRIC_MUL_W-1:0] METRIC_MUL  = 31'd1099511628;

  // datapath widths
  localparam int Z_W   = 24;
  localparam int DX_W  = 19;
  localparam int PX_W  = DX_W + INV_W + 1;
  localparam int T_W   = PX_W - 16;
  localparam int PM_W  = T_W + Z_W + 1;
  localparam int RND_W = PM_W - 16;

  // disparity divider: quotient of an accepted pixel never exceeds 10 m in Q16.16
  localparam int DEN_W      = 32;
  localparam int QUO_W      = 20;
  localparam int DVD_W      = NUM_W + 16 + 1;
  localparam int DIV_STAGES = QUO_W;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
  } div_t;

  typedef struct packed {
    logic                  ok;
    logic                  mode;
    logic signed [T_W-1:0] t_x;
    logic signed [T_W-1:0] t_y;
    logic [Z_W-1:0]        zm;
    rgb_t                  rgb;
  } side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [COORD_W-1:0]        point_z;
    logic                      point_valid;
    rgb_t                      rgb;
  } out_t;

  // one restoring division step: one quotient bit
  function automatic div_t div_step(div_t s);
    div_t           o;
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    sh   = {s.rem, s.low[QUO_W-1]};
    diff = sh - {1'b0, s.den};
    o    = s;
    o.low = {s.low[QUO_W-2:0], 1'b0};
    if (sh >= {1'b0, s.den}) begin
      o.rem = diff[DEN_W-1:0];
      o.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = sh[DEN_W-1:0];
      o.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // clamp a rounded coordinate to the signed 32-bit range
  function automatic logic [COORD_W-1:0] sat_coord(logic [RND_W-1:0] v);
    logic [RND_W-COORD_W:0] top;
    top = v[RND_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      return v[COORD_W-1:0];
    end else if (v[RND_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/dpb_pix_if.sv =====
// pixel input channel: valid/ready handshake with column, row, depth and color
interface dpb_pix_if import dpb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   column;
  logic [ROW_W-1:0]   row;
  logic [DEPTH_W-1:0] depth_word;
  logic [COLOR_W-1:0] in_red;
  logic [COLOR_W-1:0] in_green;
  logic [COLOR_W-1:0] in_blue;

  modport source (output valid, column, row, depth_word, in_red, in_green, in_blue,
                  input ready);
  modport sink (input valid, column, row, depth_word, in_red, in_green, in_blue,
                output ready);
endinterface

// ===== rtl/dpb_pt_if.sv =====
// point output channel: valid/ready handshake with the 3-d point and color
interface dpb_pt_if import dpb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [COORD_W-1:0]        point_z;
  logic                      point_valid;
  logic [COLOR_W-1:0]        out_red;
  logic [COLOR_W-1:0]        out_green;
  logic [COLOR_W-1:0]        out_blue;

  modport source (output valid, point_x, point_y, point_z, point_valid, out_red,
                  out_green, out_blue, input ready);
  modport sink (input valid, point_x, point_y, point_z, point_valid, out_red,
                out_green, out_blue, output ready);
endinterface

// ===== rtl/depth_pixel_backprojection_top.sv =====
// depth pixel back-projection: pixel stream in, camera-space point stream out
//
// in_pix carries one pixel per transaction (column, row, raw depth, color);
// out_pt returns one point per pixel, in order: x, y, z in Q16.16 meters,
// a valid flag (zero point when the pixel or its depth is rejected) and the color.
// cfg_we/cfg_index/cfg_wdata write the camera registers; write them only
// while no pixel is in flight.
// throughput: one pixel per clock, sustained while the skid buffer is empty.
// pipeline: input register, product register, twenty disparity divider stages
// of one quotient bit each, multiply register and output register.
// reset (synchronous, rst_n low) empties the pipeline and loads the default
// camera registers; no clearing pass is needed.
// when out_pt is stalled the result holds in the output register and a
// one-entry skid buffer; in_pix.ready drops while that buffer is full and
// the whole pipeline holds, so nothing is lost or repeated.
module depth_pixel_backprojection_top import dpb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dpb_pix_if.sink               in_pix,
  dpb_pt_if.source              out_pt,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LAST = DIV_STAGES - 1;

  // configuration registers
  logic             cfg_mode_r;
  logic [CX_W-1:0]  cfg_cx_r;
  logic [CY_W-1:0]  cfg_cy_r;
  logic [INV_W-1:0] cfg_ifx_r;
  logic [INV_W-1:0] cfg_ify_r;
  logic [NUM_W-1:0] cfg_num_r;
  logic [NUM_W-1:0] cfg_off_r;

  logic en;

  // stage 1
  logic                   s1_v_r;
  logic [DEPTH_W-1:0]     s1_d_r;
  logic [DEN_W:0]         s1_den_r;
  logic signed [DX_W-1:0] s1_dx_r;
  logic signed [DX_W-1:0] s1_dy_r;
  logic                   s1_frame_ok_r;
  rgb_t                   s1_rgb_r;
  logic [DEN_W:0]         s1_den_nxt;
  logic signed [DX_W-1:0] s1_dx_nxt;
  logic signed [DX_W-1:0] s1_dy_nxt;
  logic                   s1_frame_ok_nxt;

  // stage 2
  logic                    s2_v_r;
  logic signed [PX_W-1:0]  s2_px_r;
  logic signed [PX_W-1:0]  s2_py_r;
  logic [Z_W-1:0]          s2_zm_r;
  logic [DVD_W-1:0]        s2_dvd_r;
  logic [DEN_W-1:0]        s2_den_r;
  logic                    s2_ok_r;
  logic                    s2_mode_r;
  rgb_t                    s2_rgb_r;
  logic [DEN_W-1:0]        ud;
  logic                    den_pos;
  logic [NUM_W+3:0]        num10;
  logic [NUM_W+3:0]        den10;
  logic                    m0_ok;
  logic                    m1_ok;
  logic [METRIC_N_W-1:0]   metric_n;
  logic [METRIC_PROD_W-1:0] metric_prod;
  logic signed [PX_W-1:0]  s2_px_nxt;
  logic signed [PX_W-1:0]  s2_py_nxt;
  logic [DVD_W-1:0]        s2_dvd_nxt;
  logic                    s2_ok_nxt;

  // divider stages
  logic                   dv_v_r    [DIV_STAGES];
  div_t                   dv_r      [DIV_STAGES];
  side_t                  dv_side_r [DIV_STAGES];
  div_t                   dv_init;
  side_t                  side_init;
  logic signed [PX_W-1:0] rnd_px;
  logic signed [PX_W-1:0] rnd_py;

  // multiply stage
  logic                   m_v_r;
  logic signed [PM_W-1:0] m_px_r;
  logic signed [PM_W-1:0] m_py_r;
  logic [Z_W-1:0]         m_z_r;
  logic                   m_ok_r;
  rgb_t                   m_rgb_r;
  side_t                  last_side;
  logic [Z_W-1:0]         z_sel;
  logic signed [T_W-1:0]  tx_s;
  logic signed [T_W-1:0]  ty_s;
  logic signed [PM_W-1:0] m_px_nxt;
  logic signed [PM_W-1:0] m_py_nxt;

  // output register and skid buffer
  logic                   out_v_r;
  logic                   sk_v_r;
  out_t                   out_r;
  out_t                   sk_r;
  logic                   out_v_nxt;
  logic                   sk_v_nxt;
  out_t                   out_nxt;
  out_t                   sk_nxt;
  out_t                   em;
  logic signed [PM_W-1:0] rx_sum;
  logic signed [PM_W-1:0] ry_sum;
  logic                   take;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r <= RST_DEPTH_MODE;
      cfg_cx_r   <= RST_CENTER_X;
      cfg_cy_r   <= RST_CENTER_Y;
      cfg_ifx_r  <= RST_INV_FOCAL;
      cfg_ify_r  <= RST_INV_FOCAL;
      cfg_num_r  <= RST_DISP_NUM;
      cfg_off_r  <= RST_DISP_OFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH_MODE:  cfg_mode_r <= cfg_wdata[0];
        REG_CENTER_X:    cfg_cx_r   <= cfg_wdata[CX_W-1:0];
        REG_CENTER_Y:    cfg_cy_r   <= cfg_wdata[CY_W-1:0];
        REG_INV_FOCAL_X: cfg_ifx_r  <= cfg_wdata[INV_W-1:0];
        REG_INV_FOCAL_Y: cfg_ify_r  <= cfg_wdata[INV_W-1:0];
        REG_DISP_NUM:    cfg_num_r  <= cfg_wdata[NUM_W-1:0];
        REG_DISP_OFFSET: cfg_off_r  <= cfg_wdata[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline moves unless the skid buffer holds a result
  assign en           = !sk_v_r;
  assign in_pix.ready = en;

  // ---------------- stage 1: offsets and disparity denominator ----------------
  always_comb begin
    s1_den_nxt = {1'b0, cfg_off_r}
               - {1'b0, in_pix.depth_word[7:0], in_pix.depth_word[15:8], 16'b0};
    s1_dx_nxt  = $signed({1'b0, in_pix.column, 8'b0} - {1'b0, cfg_cx_r});
    s1_dy_nxt  = $signed({2'b0, in_pix.row, 8'b0} - {2'b0, cfg_cy_r});
    s1_frame_ok_nxt = (FRAME_CMP_W'(in_pix.column) < FRAME_CMP_W'(FRAME_WIDTH))
                   && (FRAME_CMP_W'(in_pix.row) < FRAME_CMP_W'(FRAME_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r         <= in_pix.depth_word;
      s1_den_r       <= s1_den_nxt;
      s1_dx_r        <= s1_dx_nxt;
      s1_dy_r        <= s1_dy_nxt;
      s1_frame_ok_r  <= s1_frame_ok_nxt;
      s1_rgb_r.red   <= in_pix.in_red;
      s1_rgb_r.green <= in_pix.in_green;
      s1_rgb_r.blue  <= in_pix.in_blue;
    end
  end

  // ---------------- stage 2: multiplies and range checks ----------------
  always_comb begin
    ud      = s1_den_r[DEN_W-1:0];
    den_pos = !s1_den_r[DEN_W] && (|ud);
    num10   = {1'b0, cfg_num_r, 3'b0} + {3'b0, cfg_num_r, 1'b0};
    den10   = {1'b0, ud, 3'b0} + {3'b0, ud, 1'b0};
    // 0.1 m <= num/den <= 10 m, checked on the exact ratio
    m1_ok   = den_pos && (num10 >= {4'b0, ud}) && ({4'b0, cfg_num_r} <= den10);
    m0_ok   = (s1_d_r != DEPTH_MISSING) && (s1_d_r >= DEPTH_MIN);
    metric_n    = {1'b0, s1_d_r, 13'b0} + METRIC_BIAS;
    metric_prod = METRIC_PROD_W'(metric_n) * METRIC_PROD_W'(METRIC_MUL);
    s2_px_nxt   = s1_dx_r * $signed({1'b0, cfg_ifx_r});
    s2_py_nxt   = s1_dy_r * $signed({1'b0, cfg_ify_r});
    // numerator * 2^16 plus half the denominator, for round-to-nearest
    s2_dvd_nxt  = {1'b0, cfg_num_r, 16'b0} + {18'b0, ud[DEN_W-1:1]};
    s2_ok_nxt   = s1_frame_ok_r && (cfg_mode_r ? m1_ok : m0_ok);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_px_r   <= s2_px_nxt;
      s2_py_r   <= s2_py_nxt;
      s2_zm_r   <= metric_prod[METRIC_PROD_W-1 -: Z_W];
      s2_dvd_r  <= s2_dvd_nxt;
      s2_den_r  <= ud;
      s2_ok_r   <= s2_ok_nxt;
      s2_mode_r <= cfg_mode_r;
      s2_rgb_r  <= s1_rgb_r;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  always_comb begin
    dv_init.rem = DEN_W'(s2_dvd_r[DVD_W-1:QUO_W]);
    dv_init.low = s2_dvd_r[QUO_W-1:0];
    dv_init.quo = '0;
    dv_init.den = s2_den_r;
    rnd_px = s2_px_r + PX_W'(32768);
    rnd_py = s2_py_r + PX_W'(32768);
    side_init.ok   = s2_ok_r;
    side_init.mode = s2_mode_r;
    side_init.t_x  = rnd_px[PX_W-1 -: T_W];
    side_init.t_y  = rnd_py[PX_W-1 -: T_W];
    side_init.zm   = s2_zm_r;
    side_init.rgb  = s2_rgb_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]      <= div_step(dv_init);
      dv_side_r[0] <= side_init;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_r[k]      <= div_step(dv_r[k-1]);
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  // ---------------- multiply stage: t * z ----------------
  always_comb begin
    last_side = dv_side_r[LAST];
    z_sel     = last_side.mode ? Z_W'(dv_r[LAST].quo) : last_side.zm;
    tx_s      = last_side.t_x;
    ty_s      = last_side.t_y;
    m_px_nxt  = tx_s * $signed({1'b0, z_sel});
    m_py_nxt  = ty_s * $signed({1'b0, z_sel});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_px_r  <= m_px_nxt;
      m_py_r  <= m_py_nxt;
      m_z_r   <= z_sel;
      m_ok_r  <= last_side.ok;
      m_rgb_r <= last_side.rgb;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      m_v_r  <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      s1_v_r    <= in_pix.valid;
      s2_v_r    <= s1_v_r;
      dv_v_r[0] <= s2_v_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
      m_v_r <= dv_v_r[LAST];
    end
  end

  // ---------------- rounding, saturation, output and skid ----------------
  always_comb begin
    rx_sum = m_px_r + PM_W'(32768);
    ry_sum = m_py_r + PM_W'(32768);
    em.point_x     = m_ok_r ? sat_coord(rx_sum[PM_W-1:16]) : '0;
    em.point_y     = m_ok_r ? sat_coord(ry_sum[PM_W-1:16]) : '0;
    em.point_z     = m_ok_r ? COORD_W'(m_z_r) : '0;
    em.point_valid = m_ok_r;
    em.rgb         = m_rgb_r;
  end

  always_comb begin
    take      = !out_v_r || out_pt.ready;
    out_v_nxt = out_v_r;
    sk_v_nxt  = sk_v_r;
    out_nxt   = out_r;
    sk_nxt    = sk_r;
    if (sk_v_r) begin
      if (take) begin
        out_v_nxt = 1'b1;
        out_nxt   = sk_r;
        sk_v_nxt  = 1'b0;
      end
    end else if (m_v_r) begin
      if (take) begin
        out_v_nxt = 1'b1;
        out_nxt   = em;
      end else begin
        sk_v_nxt = 1'b1;
        sk_nxt   = em;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sk_r  <= sk_nxt;
  end

  assign out_pt.valid       = out_v_r;
  assign out_pt.point_x     = out_r.point_x;
  assign out_pt.point_y     = out_r.point_y;
  assign out_pt.point_z     = out_r.point_z;
  assign out_pt.point_valid = out_r.point_valid;
  assign out_pt.out_red     = out_r.rgb.red;
  assign out_pt.out_green   = out_r.rgb.green;
  assign out_pt.out_blue    = out_r.rgb.blue;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid buffer holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(out_v_r && !out_pt.ready))
    else $error("skid buffer filled without an output stall");

  a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pt.valid && !out_pt.point_valid) |->
      (out_pt.point_x == '0 && out_pt.point_y == '0 && out_pt.point_z == '0))
    else $error("rejected point carries nonzero coordinates");

  a_valid_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pt.valid && out_pt.point_valid) |-> (out_pt.point_z != '0))
    else $error("accepted point has zero depth");
`endif

endmodule
